>>> sv/stt_pkg.sv
// Package with constants, types and keyword table of the source text tokenizer.
`timescale 1ns / 1ps
package stt_pkg;

	localparam int OFFSET_BITS   = 32;
	localparam int KEYWORD_CHARS = 10;
	localparam int LENGTH_BITS   = 16;
	localparam int NUM_KEYWORDS  = 38;
	localparam int FIFO_DEPTH    = 4;

	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_NUMBER = 2'd1;
	localparam logic [1:0] MODE_IDENT  = 2'd2;
	localparam logic [1:0] MODE_OPER   = 2'd3;

	localparam logic [2:0] KIND_NUMBER = 3'd0;
	localparam logic [2:0] KIND_IDENT  = 3'd1;
	localparam logic [2:0] KIND_KEYWORD = 3'd2;
	localparam logic [2:0] KIND_OPER   = 3'd3;
	localparam logic [2:0] KIND_DELIM  = 3'd4;
	localparam logic [2:0] KIND_END    = 3'd5;

	// Keyword text is right-aligned: the first character sits in the highest used byte.
	localparam logic [79:0] KW_TEXT [NUM_KEYWORDS] = '{
		80'("function"), 80'("class"), 80'("struct"), 80'("enum"), 80'("interface"),
		80'("number"), 80'("int"), 80'("float"), 80'("bool"), 80'("string"),
		80'("array"), 80'("dictionary"), 80'("set"), 80'("true"), 80'("false"),
		80'("null"), 80'("if"), 80'("else"), 80'("for"), 80'("foreach"),
		80'("while"), 80'("break"), 80'("continue"), 80'("switch"), 80'("case"),
		80'("default"), 80'("try"), 80'("catch"), 80'("throw"), 80'("async"),
		80'("await"), 80'("yield"), 80'("return"), 80'("static"), 80'("override"),
		80'("decorator"), 80'("as"), 80'("with")
	};

	localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
		4'd8, 4'd5, 4'd6, 4'd4, 4'd9, 4'd6, 4'd3, 4'd5, 4'd4, 4'd6,
		4'd5, 4'd10, 4'd3, 4'd4, 4'd5, 4'd4, 4'd2, 4'd4, 4'd3, 4'd7,
		4'd5, 4'd5, 4'd8, 4'd6, 4'd4, 4'd7, 4'd3, 4'd5, 4'd5, 4'd5,
		4'd5, 4'd5, 4'd6, 4'd6, 4'd8, 4'd9, 4'd2, 4'd4
	};

	typedef struct packed {
		logic [2:0]  kind;
		logic [5:0]  code;
		logic [31:0] start_res;
		logic [15:0] length;
		logic        end_mark;
	} res_t;

endpackage

>>> sv/source_text_tokenizer_core.sv
// Top level of the source text tokenizer: byte scanner, keyword match and result queue.
`timescale 1ns / 1ps
// Takes one source byte per request and emits number, identifier, keyword,
// operator, delimiter and end-of-text tokens. A byte is decoded in the cycle it
// is taken; its zero to three results go into a four-entry result queue that
// drains one result per cycle unless m_tready is low. A new byte is taken whenever
// the queue holds at most one result, so bytes that each cause at most one result
// flow at one per cycle unless m_tready is low, and more results hold off later bytes.
module source_text_tokenizer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // ch[7:0]
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // code[5:0], start_res[37:6], length[53:38], zero pad
	output logic [2:0]  m_tuser,   // kind[2:0]
	output logic        m_tlast    // end_mark
);

	localparam int LEN_MAX = (2 ** stt_pkg::LENGTH_BITS) - 1;

	logic [1:0]                         mode_q;
	logic [7:0]                         nb_q [stt_pkg::KEYWORD_CHARS];
	logic [stt_pkg::LENGTH_BITS-1:0]    len_q;
	logic [stt_pkg::OFFSET_BITS-1:0]    start_q;
	logic [stt_pkg::OFFSET_BITS-1:0]    off_q;
	logic [7:0]                         pend_q;

	stt_pkg::res_t fifo_q [stt_pkg::FIFO_DEPTH];
	logic [1:0] wptr_q, rptr_q;
	logic [2:0] count_q;

	logic [1:0]                      nm;
	logic [7:0]                      nb [stt_pkg::KEYWORD_CHARS];
	logic [stt_pkg::LENGTH_BITS-1:0] nl;
	logic [stt_pkg::OFFSET_BITS-1:0] ns, noff;
	logic [7:0]                      np;
	stt_pkg::res_t                   res [3];
	logic [1:0]                      nres;
	logic                            used;
	logic                            take, pop;
	logic [7:0]                      c;

	function automatic stt_pkg::res_t mk(input logic [2:0] kind, input logic [5:0] code,
			input logic [stt_pkg::OFFSET_BITS-1:0] start,
			input logic [stt_pkg::LENGTH_BITS-1:0] len, input logic endm);
		stt_pkg::res_t r;
		logic [63:0] s64;
		logic [31:0] l32;
		s64 = 64'(start);
		l32 = 32'(len);
		r.kind = kind;
		r.code = code;
		r.start_res = s64[31:0];
		r.length = (l32 > 32'd65535) ? 16'hFFFF : l32[15:0];
		r.end_mark = endm;
		return r;
	endfunction

	function automatic logic [6:0] kw_lookup(input logic [7:0] b [stt_pkg::KEYWORD_CHARS],
			input logic [stt_pkg::LENGTH_BITS-1:0] len);
		logic [6:0] hit;
		logic same;
		int pos;
		hit = '0;
		for (int k = stt_pkg::NUM_KEYWORDS - 1; k >= 0; k--) begin
			same = (32'(len) == 32'(stt_pkg::KW_LEN[k]));
			for (int i = 0; i < stt_pkg::KEYWORD_CHARS; i++) begin
				if (i < int'(stt_pkg::KW_LEN[k])) begin
					pos = 8 * (int'(stt_pkg::KW_LEN[k]) - 1 - i);
					if (b[i] != stt_pkg::KW_TEXT[k][pos +: 8]) same = 1'b0;
				end
			end
			if (same) hit = {1'b1, 6'(k)};
		end
		return hit;
	endfunction

	function automatic logic [4:0] single_op(input logic [7:0] ch);
		logic [4:0] r;
		case (ch)
			8'h2B: r = {1'b1, 4'd0};
			8'h2D: r = {1'b1, 4'd1};
			8'h2A: r = {1'b1, 4'd2};
			8'h2F: r = {1'b1, 4'd3};
			8'h25: r = {1'b1, 4'd4};
			8'h5E: r = {1'b1, 4'd5};
			8'h3C: r = {1'b1, 4'd8};
			8'h3E: r = {1'b1, 4'd9};
			8'h21: r = {1'b1, 4'd14};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] pair_op(input logic [7:0] a, input logic [7:0] b);
		logic [4:0] r;
		r = '0;
		if (a == 8'h3D && b == 8'h3D) r = {1'b1, 4'd6};
		if (a == 8'h21 && b == 8'h3D) r = {1'b1, 4'd7};
		if (a == 8'h3C && b == 8'h3D) r = {1'b1, 4'd10};
		if (a == 8'h3E && b == 8'h3D) r = {1'b1, 4'd11};
		if (a == 8'h26 && b == 8'h26) r = {1'b1, 4'd12};
		if (a == 8'h7C && b == 8'h7C) r = {1'b1, 4'd13};
		return r;
	endfunction

	function automatic logic [3:0] delim(input logic [7:0] ch);
		logic [3:0] r;
		case (ch)
			8'h28: r = {1'b1, 3'd0};
			8'h29: r = {1'b1, 3'd1};
			8'h7B: r = {1'b1, 3'd2};
			8'h7D: r = {1'b1, 3'd3};
			8'h3B: r = {1'b1, 3'd4};
			8'h2C: r = {1'b1, 3'd5};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [stt_pkg::LENGTH_BITS-1:0] inc_sat(
			input logic [stt_pkg::LENGTH_BITS-1:0] v);
		return (32'(v) < 32'(LEN_MAX)) ? v + 1'b1 : v;
	endfunction

	// Flush result for a pending token; the top bit says whether one exists.
	function automatic logic [$bits(stt_pkg::res_t):0] flush_res(input logic [1:0] mode,
			input logic [7:0] b [stt_pkg::KEYWORD_CHARS],
			input logic [stt_pkg::LENGTH_BITS-1:0] len,
			input logic [stt_pkg::OFFSET_BITS-1:0] start, input logic [7:0] pend);
		logic [6:0] kw;
		logic [4:0] so;
		stt_pkg::res_t r;
		logic v;
		kw = kw_lookup(b, len);
		so = single_op(pend);
		v = 1'b0;
		r = mk(stt_pkg::KIND_NUMBER, 6'd0, start, len, 1'b0);
		unique case (mode)
			stt_pkg::MODE_NUMBER: v = 1'b1;
			stt_pkg::MODE_IDENT: begin
				v = 1'b1;
				if (kw[6]) r = mk(stt_pkg::KIND_KEYWORD, kw[5:0], start, len, 1'b0);
				else r = mk(stt_pkg::KIND_IDENT, 6'd0, start, len, 1'b0);
			end
			stt_pkg::MODE_OPER: begin
				v = so[4];
				r = mk(stt_pkg::KIND_OPER, {2'b00, so[3:0]}, start,
					stt_pkg::LENGTH_BITS'(1), 1'b0);
			end
			default: v = 1'b0;
		endcase
		return {v, r};
	endfunction

	always_comb begin
		logic [$bits(stt_pkg::res_t):0] fl;
		logic [4:0] po, so;
		logic [3:0] dl;
		logic is_digit, is_alpha, is_space;
		c = s_tdata;
		is_digit = (c >= 8'h30) && (c <= 8'h39);
		is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
		is_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
		po = pair_op(pend_q, c);
		so = single_op(c);
		dl = delim(c);
		nm = mode_q;
		nb = nb_q;
		nl = len_q;
		ns = start_q;
		np = pend_q;
		used = 1'b0;
		nres = 2'd0;
		res[0] = mk(stt_pkg::KIND_NUMBER, 6'd0, start_q, len_q, 1'b0);
		res[1] = res[0];
		res[2] = res[0];
		fl = flush_res(mode_q, nb_q, len_q, start_q, pend_q);

		unique case (mode_q)
			stt_pkg::MODE_OPER: begin
				nm = stt_pkg::MODE_IDLE;
				if (po[4]) begin
					res[0] = mk(stt_pkg::KIND_OPER, {2'b00, po[3:0]}, start_q,
						stt_pkg::LENGTH_BITS'(2), 1'b0);
					nres = 2'd1;
					used = 1'b1;
				end else if (fl[$bits(stt_pkg::res_t)]) begin
					res[0] = fl[$bits(stt_pkg::res_t)-1:0];
					nres = 2'd1;
				end
			end
			stt_pkg::MODE_NUMBER: begin
				if (is_digit || c == 8'h2E) begin
					nl = inc_sat(len_q);
					used = 1'b1;
				end else begin
					res[0] = fl[$bits(stt_pkg::res_t)-1:0];
					nres = 2'd1;
					nm = stt_pkg::MODE_IDLE;
				end
			end
			stt_pkg::MODE_IDENT: begin
				if (is_alpha || is_digit || c == 8'h5F) begin
					if (32'(len_q) < 32'(stt_pkg::KEYWORD_CHARS))
						nb[$clog2(stt_pkg::KEYWORD_CHARS)'(len_q)] = c;
					nl = inc_sat(len_q);
					used = 1'b1;
				end else begin
					res[0] = fl[$bits(stt_pkg::res_t)-1:0];
					nres = 2'd1;
					nm = stt_pkg::MODE_IDLE;
				end
			end
			default: ;
		endcase

		if (!used && !is_space) begin
			if (is_digit) begin
				nm = stt_pkg::MODE_NUMBER;
				ns = off_q;
				nl = stt_pkg::LENGTH_BITS'(1);
			end else if (is_alpha) begin
				nm = stt_pkg::MODE_IDENT;
				ns = off_q;
				nl = stt_pkg::LENGTH_BITS'(1);
				nb[0] = c;
			end else if (so[4] || c == 8'h3D || c == 8'h26 || c == 8'h7C) begin
				nm = stt_pkg::MODE_OPER;
				ns = off_q;
				np = c;
				nl = stt_pkg::LENGTH_BITS'(1);
			end else if (dl[3]) begin
				res[nres] = mk(stt_pkg::KIND_DELIM, {3'b000, dl[2:0]}, off_q,
					stt_pkg::LENGTH_BITS'(1), 1'b0);
				nres = nres + 2'd1;
			end
		end

		noff = off_q + 1'b1;

		if (s_tlast) begin
			fl = flush_res(nm, nb, nl, ns, np);
			if (fl[$bits(stt_pkg::res_t)]) begin
				res[nres] = fl[$bits(stt_pkg::res_t)-1:0];
				nres = nres + 2'd1;
			end
			res[nres] = mk(stt_pkg::KIND_END, 6'd0, noff, '0, 1'b1);
			nres = nres + 2'd1;
			nm = stt_pkg::MODE_IDLE;
			noff = '0;
			nl = '0;
			ns = '0;
			np = '0;
		end
	end

	assign s_tready = (count_q <= 3'd1);
	assign take = s_tvalid && s_tready;
	assign m_tvalid = (count_q != 3'd0);
	assign pop = m_tvalid && m_tready;

	assign m_tuser = fifo_q[rptr_q].kind;
	assign m_tlast = fifo_q[rptr_q].end_mark;
	assign m_tdata = {2'b00, fifo_q[rptr_q].length, fifo_q[rptr_q].start_res,
		fifo_q[rptr_q].code};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stt_pkg::MODE_IDLE;
			len_q <= '0;
			start_q <= '0;
			off_q <= '0;
			pend_q <= '0;
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (take) begin
				mode_q <= nm;
				len_q <= nl;
				start_q <= ns;
				off_q <= noff;
				pend_q <= np;
				wptr_q <= wptr_q + nres;
			end
			if (pop) rptr_q <= rptr_q + 1'b1;
			count_q <= count_q + (take ? {1'b0, nres} : 3'd0) - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			nb_q <= nb;
			for (int k = 0; k < 3; k++) begin
				if (k < int'(nres)) fifo_q[wptr_q + 2'(k)] <= res[k];
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4) else $error("result queue overflow");
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		take && s_tlast |=> m_tvalid) else $error("no result after final byte");
	a_last_resets_scan: assert property (@(posedge clk) disable iff (!arst_n)
		take && s_tlast |=> (mode_q == stt_pkg::MODE_IDLE) && (off_q == '0))
		else $error("scanner not restarted after final byte");
	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(off_q)) else $error("offset moved without a request");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the source text tokenizer: directed and random text streams.
`timescale 1ns / 1ps
module testbench;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	source_text_tokenizer_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #10 clk = ~clk;

	// Keyword spellings, in code order.
	string keywords [stt_pkg::NUM_KEYWORDS] = '{
		"function", "class", "struct", "enum", "interface",
		"number", "int", "float", "bool", "string", "array", "dictionary", "set",
		"true", "false", "null", "if", "else",
		"for", "foreach", "while", "break", "continue",
		"switch", "case", "default", "try", "catch", "throw",
		"async", "await", "yield", "return", "static", "override",
		"decorator", "as", "with"
	};

	// Scanner state of the predictor.
	logic [1:0]  lex_mode;
	logic [7:0]  lex_name [stt_pkg::KEYWORD_CHARS];
	logic [15:0] lex_len;
	logic [31:0] lex_start;
	logic [31:0] lex_offset;
	logic [7:0]  lex_pend;

	stt_pkg::res_t token_queue [$];
	int   errors = 0;
	bit   stall_enable = 1'b1;
	bit   hold_sink = 1'b0;

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic int op_single(logic [7:0] c);
		case (c)
			"+": return 0;
			"-": return 1;
			"*": return 2;
			"/": return 3;
			"%": return 4;
			"^": return 5;
			"<": return 8;
			">": return 9;
			"!": return 14;
			default: return -1;
		endcase
	endfunction

	function automatic int op_pair(logic [7:0] a, logic [7:0] b);
		if (b == "=" && a == "=") return 6;
		if (b == "=" && a == "!") return 7;
		if (b == "=" && a == "<") return 10;
		if (b == "=" && a == ">") return 11;
		if (a == "&" && b == "&") return 12;
		if (a == "|" && b == "|") return 13;
		return -1;
	endfunction

	function automatic int delim_code(logic [7:0] c);
		case (c)
			"(": return 0;
			")": return 1;
			"{": return 2;
			"}": return 3;
			";": return 4;
			",": return 5;
			default: return -1;
		endcase
	endfunction

	function automatic int keyword_code();
		bit same;
		for (int k = 0; k < stt_pkg::NUM_KEYWORDS; k++) begin
			if (keywords[k].len() != lex_len || lex_len > stt_pkg::KEYWORD_CHARS) continue;
			same = 1'b1;
			for (int i = 0; i < keywords[k].len(); i++)
				if (lex_name[i] != keywords[k][i]) same = 1'b0;
			if (same) return k;
		end
		return -1;
	endfunction

	task automatic push_token(logic [2:0] kind, int code, logic [31:0] start,
			logic [15:0] len, bit endm);
		stt_pkg::res_t r;
		r.kind = kind;
		r.code = code[5:0];
		r.start_res = start;
		r.length = len;
		r.end_mark = endm;
		token_queue = {token_queue, r};
	endtask

	task automatic extend_token(logic [7:0] c, bit keep);
		if (keep && lex_len < stt_pkg::KEYWORD_CHARS) lex_name[lex_len[3:0]] = c;
		if (lex_len != 16'hFFFF) lex_len++;
	endtask

	task automatic flush_token();
		int k;
		if (lex_mode == stt_pkg::MODE_NUMBER) begin
			push_token(stt_pkg::KIND_NUMBER, 0, lex_start, lex_len, 0);
		end else if (lex_mode == stt_pkg::MODE_IDENT) begin
			k = keyword_code();
			if (k >= 0) push_token(stt_pkg::KIND_KEYWORD, k, lex_start, lex_len, 0);
			else push_token(stt_pkg::KIND_IDENT, 0, lex_start, lex_len, 0);
		end else if (lex_mode == stt_pkg::MODE_OPER) begin
			k = op_single(lex_pend);
			if (k >= 0) push_token(stt_pkg::KIND_OPER, k, lex_start, 1, 0);
		end
		lex_mode = stt_pkg::MODE_IDLE;
	endtask

	task automatic start_token(logic [1:0] mode);
		lex_mode = mode;
		lex_start = lex_offset;
		lex_len = 0;
	endtask

	// Predicts the tokens completed by one accepted byte.
	task automatic scan_byte(logic [7:0] c, bit last);
		bit used;
		int p;
		used = 1'b0;
		if (lex_mode == stt_pkg::MODE_OPER) begin
			p = op_pair(lex_pend, c);
			if (p >= 0) begin
				push_token(stt_pkg::KIND_OPER, p, lex_start, 2, 0);
				lex_mode = stt_pkg::MODE_IDLE;
				used = 1'b1;
			end else flush_token();
		end else if (lex_mode == stt_pkg::MODE_NUMBER) begin
			if (is_digit(c) || c == ".") begin
				extend_token(c, 0);
				used = 1'b1;
			end else flush_token();
		end else if (lex_mode == stt_pkg::MODE_IDENT) begin
			if (is_alpha(c) || is_digit(c) || c == "_") begin
				extend_token(c, 1);
				used = 1'b1;
			end else flush_token();
		end
		if (!used && !(c == " " || (c >= 9 && c <= 13))) begin
			if (is_digit(c)) begin
				start_token(stt_pkg::MODE_NUMBER);
				extend_token(c, 0);
			end else if (is_alpha(c)) begin
				start_token(stt_pkg::MODE_IDENT);
				extend_token(c, 1);
			end else if (op_single(c) >= 0 || c == "=" || c == "&" || c == "|") begin
				start_token(stt_pkg::MODE_OPER);
				lex_pend = c;
				lex_len = 1;
			end else if (delim_code(c) >= 0) begin
				push_token(stt_pkg::KIND_DELIM, delim_code(c), lex_offset, 1, 0);
			end
		end
		lex_offset++;
		if (last) begin
			flush_token();
			push_token(stt_pkg::KIND_END, 0, lex_offset, 0, 1);
			lex_offset = 0;
			lex_len = 0;
			lex_start = 0;
			lex_pend = 0;
		end
	endtask

	// Sends one byte, with optional idle cycles first; predicts on acceptance.
	// The request stays valid after acceptance only until the next byte or idle cycle.
	task automatic send_byte(logic [7:0] c, bit last);
		if (stall_enable && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tdata <= c;
		s_tlast <= last;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		scan_byte(c, last);
		@(negedge clk);
	endtask

	task automatic send_text(string s, bit close);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], close && i == s.len() - 1);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (token_queue.size() != 0);
	endtask

	// Checker: compares every accepted result with the oldest prediction.
	always @(posedge clk) begin
		stt_pkg::res_t exp;
		if (arst_n && m_tvalid && m_tready) begin
			if (token_queue.size() == 0) begin
				$error("unexpected result kind=%0d", m_tuser);
				errors++;
			end else begin
				exp = token_queue.pop_front();
				if (m_tuser !== exp.kind) begin
					$error("kind: expected %0d, got %0d", exp.kind, m_tuser);
					errors++;
				end
				if (m_tdata[5:0] !== exp.code) begin
					$error("code: expected %0d, got %0d", exp.code, m_tdata[5:0]);
					errors++;
				end
				if (m_tdata[37:6] !== exp.start_res) begin
					$error("start_res: expected %0d, got %0d", exp.start_res, m_tdata[37:6]);
					errors++;
				end
				if (m_tdata[53:38] !== exp.length) begin
					$error("length: expected %0d, got %0d", exp.length, m_tdata[53:38]);
					errors++;
				end
				if (m_tlast !== exp.end_mark) begin
					$error("end_mark: expected %0d, got %0d", exp.end_mark, m_tlast);
					errors++;
				end
			end
		end
	end

	// Receiver readiness with random stall bursts and an optional long hold.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_sink) m_tready <= 1'b0;
			else if (stall_enable && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
				m_tready <= 1'b1;
			end else m_tready <= 1'b1;
		end
	end

	task automatic test_directed();
		send_text("function x1 dictionary dictionaryx 12.3.4 ", 0);
		send_text("a_b9 Z == != <= >= && || ", 0);
		send_text("+-*/%^<>! = & | ({});, ", 0);
		send_byte(8'h00, 0);
		send_byte(8'hFF, 0);
		send_byte(8'h7F, 0);
		send_text("\t\n\v\f\rwith", 1);
		send_text("<", 1);
		send_text("7", 1);
		send_byte("=", 1);
		send_byte(8'h80, 1);
	endtask

	task automatic test_keywords();
		for (int k = 0; k < stt_pkg::NUM_KEYWORDS; k++)
			send_text({keywords[k], " "}, k == stt_pkg::NUM_KEYWORDS - 1);
	endtask

	function automatic logic [7:0] pick_char();
		string pool;
		pool = "abcdefwhilsnt_019.+-*/%^<>!=&|(){};, \t";
		case ($urandom_range(0, 9))
			0: return 8'($urandom_range(0, 255));
			default: return pool[$urandom_range(0, pool.len() - 1)];
		endcase
	endfunction

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_text({keywords[$urandom_range(0, stt_pkg::NUM_KEYWORDS - 1)], " "}, 0);
			else
				send_byte(pick_char(), $urandom_range(0, 40) == 0);
		end
		send_byte(" ", 1);
	endtask

	// Sink holds off while the source keeps offering bytes.
	task automatic test_backpressure();
		fork
			send_text("a ( ) 1 ; b , { } c", 1);
			begin
				hold_sink = 1'b1;
				repeat (60) @(negedge clk);
				hold_sink = 1'b0;
			end
		join
		wait_drained();
	endtask

	initial begin
		lex_mode = stt_pkg::MODE_IDLE;
		lex_len = 0;
		lex_start = 0;
		lex_offset = 0;
		lex_pend = 0;
		for (int i = 0; i < stt_pkg::KEYWORD_CHARS; i++) lex_name[i] = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_keywords();
		wait_drained();
		test_backpressure();
		test_random(20);
		stall_enable = 0;
		test_random(10);
		wait_drained();
		repeat (20) @(negedge clk);
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
sv/stt_pkg.sv
sv/source_text_tokenizer_core.sv
tb/sv/testbench.sv
